// ----- design/sic_pkg.sv -----
// segment intersection core: shared types and constants
// status codes and the control word carried down the divider chain
// no dependencies
`timescale 1ns / 1ps

package sic_pkg;

   localparam int TOL_WIDTH = 16;

   typedef enum logic [1:0] {
      ST_CROSS        = 2'd0,
      ST_APART_FIRST  = 2'd1,
      ST_APART_SECOND = 2'd2,
      ST_PARALLEL     = 2'd3
   } status_type;

   typedef struct packed {
      status_type status;
      logic       neg_x;
      logic       neg_y;
      logic       ovf_x;
      logic       ovf_y;
   } ctl_type;

endpackage

// ----- design/sic_front.sv -----
// segment intersection core: front pipeline (line equations, side tests, numerators)
// four registered stages feeding the first divider cell
// depends on sic_pkg
`timescale 1ns / 1ps

module sic_front #(
   parameter int W = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sic_pkg::TOL_WIDTH-1:0]       tol,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [8*W-1:0]                      in_data,
   output logic                                out_valid,
   input  logic                                out_ready,
   output sic_pkg::ctl_type                    out_ctl,
   output logic [2*W+1:0]                      out_dm,
   output logic [3*W+1:0]                      out_ax,
   output logic [3*W+1:0]                      out_ay
);

   localparam int AW  = W + 1;
   localparam int CW  = 2 * W + 1;
   localparam int SW  = 2 * W + 3;
   localparam int DMW = 2 * W + 2;
   localparam int NW  = 3 * W + 3;
   localparam int NMW = 3 * W + 4;
   localparam int Q   = W;
   localparam int RW  = NMW - Q;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic r1, r2, r3, r4;

   assign r4       = !v4_ff || out_ready;
   assign r3       = !v3_ff || r4;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;
   assign out_valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
      end
   end

   // stage 1: line coefficients
   logic signed [W-1:0]  crd [8];
   logic signed [W-1:0]  pt_in [8];
   logic signed [W-1:0]  pt_ff [8];
   logic signed [AW-1:0] a1_in, b1_in, a2_in, b2_in;
   logic signed [AW-1:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [CW-1:0] c1_in, c2_in, c1_ff, c2_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         crd[i]   = in_data[i*W +: W];
         pt_in[i] = crd[i];
      end
      a1_in = AW'(crd[3]) - AW'(crd[1]);
      b1_in = AW'(crd[0]) - AW'(crd[2]);
      c1_in = CW'(crd[2]) * CW'(crd[1]) - CW'(crd[0]) * CW'(crd[3]);
      a2_in = AW'(crd[7]) - AW'(crd[5]);
      b2_in = AW'(crd[4]) - AW'(crd[6]);
      c2_in = CW'(crd[6]) * CW'(crd[5]) - CW'(crd[4]) * CW'(crd[7]);
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         pt_ff <= pt_in;
         a1_ff <= a1_in;
         b1_ff <= b1_in;
         c1_ff <= c1_in;
         a2_ff <= a2_in;
         b2_ff <= b2_in;
         c2_ff <= c2_in;
      end
   end

   // stage 2: side values, denominator, numerator products
   logic signed [SW-1:0] s13_in, s14_in, s21_in, s22_in, den_in;
   logic signed [SW-1:0] s13_ff, s14_ff, s21_ff, s22_ff, den_ff;
   logic signed [NW-1:0] p1_in, p2_in, p3_in, p4_in;
   logic signed [NW-1:0] p1_ff, p2_ff, p3_ff, p4_ff;

   always_comb begin
      s13_in = SW'(a1_ff) * SW'(pt_ff[4]) + SW'(b1_ff) * SW'(pt_ff[5]) + SW'(c1_ff);
      s14_in = SW'(a1_ff) * SW'(pt_ff[6]) + SW'(b1_ff) * SW'(pt_ff[7]) + SW'(c1_ff);
      s21_in = SW'(a2_ff) * SW'(pt_ff[0]) + SW'(b2_ff) * SW'(pt_ff[1]) + SW'(c2_ff);
      s22_in = SW'(a2_ff) * SW'(pt_ff[2]) + SW'(b2_ff) * SW'(pt_ff[3]) + SW'(c2_ff);
      den_in = SW'(a1_ff) * SW'(b2_ff) - SW'(a2_ff) * SW'(b1_ff);
      p1_in  = NW'(b1_ff) * NW'(c2_ff);
      p2_in  = NW'(b2_ff) * NW'(c1_ff);
      p3_in  = NW'(a2_ff) * NW'(c1_ff);
      p4_in  = NW'(a1_ff) * NW'(c2_ff);
   end

   always_ff @(posedge clock) begin
      if (r2) begin
         s13_ff <= s13_in;
         s14_ff <= s14_in;
         s21_ff <= s21_in;
         s22_ff <= s22_in;
         den_ff <= den_in;
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         p3_ff  <= p3_in;
         p4_ff  <= p4_in;
      end
   end

   // stage 3: tolerance tests and status
   function automatic logic on_line(logic signed [SW-1:0] s, logic [sic_pkg::TOL_WIDTH-1:0] t);
      logic [SW-1:0] m;
      m = s[SW-1] ? SW'(-s) : SW'(s);
      return m <= SW'(t);
   endfunction

   logic z13, z14, z21, z22, apart1, apart2;
   sic_pkg::status_type  st3_in, st3_ff;
   logic signed [NW-1:0] nx_in, ny_in, nx_ff, ny_ff;
   logic [SW-1:0]        dabs;
   logic [DMW-1:0]       dm3_in, dm3_ff;
   logic                 dneg_ff;

   always_comb begin
      z13    = on_line(s13_ff, tol);
      z14    = on_line(s14_ff, tol);
      z21    = on_line(s21_ff, tol);
      z22    = on_line(s22_ff, tol);
      apart1 = !z13 && !z14 && (s13_ff[SW-1] == s14_ff[SW-1]);
      apart2 = !z21 && !z22 && (s21_ff[SW-1] == s22_ff[SW-1]);
      priority if (apart1) st3_in = sic_pkg::ST_APART_FIRST;
      else if (apart2)     st3_in = sic_pkg::ST_APART_SECOND;
      else if (den_ff == '0) st3_in = sic_pkg::ST_PARALLEL;
      else                 st3_in = sic_pkg::ST_CROSS;
      nx_in  = p1_ff - p2_ff;
      ny_in  = p3_ff - p4_ff;
      dabs   = den_ff[SW-1] ? SW'(-den_ff) : SW'(den_ff);
      dm3_in = dabs[DMW-1:0];
   end

   always_ff @(posedge clock) begin
      if (r3) begin
         st3_ff  <= st3_in;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         dm3_ff  <= dm3_in;
         dneg_ff <= den_ff[SW-1];
      end
   end

   // stage 4: numerator magnitudes with half divisor added
   logic [NMW-1:0]      nmx_in, nmy_in, nmx_ff, nmy_ff;
   logic [NW-1:0]       ax_abs, ay_abs;
   sic_pkg::status_type st4_ff;
   logic                negx_ff, negy_ff;
   logic [DMW-1:0]      dm4_ff;

   always_comb begin
      ax_abs = nx_ff[NW-1] ? NW'(-nx_ff) : NW'(nx_ff);
      ay_abs = ny_ff[NW-1] ? NW'(-ny_ff) : NW'(ny_ff);
      nmx_in = NMW'(ax_abs) + NMW'(dm3_ff >> 1);
      nmy_in = NMW'(ay_abs) + NMW'(dm3_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (r4) begin
         nmx_ff  <= nmx_in;
         nmy_ff  <= nmy_in;
         st4_ff  <= st3_ff;
         negx_ff <= nx_ff[NW-1] ^ dneg_ff;
         negy_ff <= ny_ff[NW-1] ^ dneg_ff;
         dm4_ff  <= dm3_ff;
      end
   end

   logic [RW-1:0] remx, remy;

   always_comb begin
      remx           = nmx_ff[NMW-1:Q];
      remy           = nmy_ff[NMW-1:Q];
      out_ctl.status = st4_ff;
      out_ctl.neg_x  = negx_ff;
      out_ctl.neg_y  = negy_ff;
      out_ctl.ovf_x  = remx >= RW'(dm4_ff);
      out_ctl.ovf_y  = remy >= RW'(dm4_ff);
      out_dm         = dm4_ff;
      out_ax         = {remx[DMW-1:0], nmx_ff[Q-1:0]};
      out_ay         = {remy[DMW-1:0], nmy_ff[Q-1:0]};
   end

endmodule

// ----- design/sic_div_cell.sv -----
// segment intersection core: one restoring division cell
// produces one quotient bit for x and for y per beat, handing on to the next cell
// depends on sic_pkg
`timescale 1ns / 1ps

module sic_div_cell #(
   parameter int DMW = 34,
   parameter int Q   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  sic_pkg::ctl_type     in_ctl,
   input  logic [DMW-1:0]       in_dm,
   input  logic [DMW+Q-1:0]     in_ax,
   input  logic [DMW+Q-1:0]     in_ay,
   output logic                 out_valid,
   input  logic                 out_ready,
   output sic_pkg::ctl_type     out_ctl,
   output logic [DMW-1:0]       out_dm,
   output logic [DMW+Q-1:0]     out_ax,
   output logic [DMW+Q-1:0]     out_ay
);

   logic                 valid_ff;
   sic_pkg::ctl_type     ctl_ff;
   logic [DMW-1:0]       dm_ff;
   logic [DMW+Q-1:0]     ax_ff, ay_ff, ax_in, ay_in;

   function automatic logic [DMW+Q-1:0] step(logic [DMW+Q-1:0] acc, logic [DMW-1:0] d);
      logic [DMW:0] t;
      logic [DMW:0] diff;
      logic         ge;
      t    = {acc[DMW+Q-1:Q], acc[Q-1]};
      diff = t - {1'b0, d};
      ge   = t >= {1'b0, d};
      return {ge ? diff[DMW-1:0] : t[DMW-1:0], acc[Q-2:0], ge};
   endfunction

   assign in_ready = !valid_ff || out_ready;
   assign ax_in    = step(in_ax, in_dm);
   assign ay_in    = step(in_ay, in_dm);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         ctl_ff <= in_ctl;
         dm_ff  <= in_dm;
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_dm    = dm_ff;
   assign out_ax    = ax_ff;
   assign out_ay    = ay_ff;

endmodule

// ----- design/segment_intersection_core.sv -----
// Segment intersection core. Takes one pair of segments per beat on req_ and returns
// status and rounded, saturated crossing point on rsp_, one result per pair in order.
// A new pair enters every cycle unless rsp_ stalls; path: four front stages, a divider
// cell per quotient bit, output register. The user writes side_tolerance on csr_ only
// while the core is idle; not enforced. Depends on sic_pkg, sic_front, sic_div_cell.
`timescale 1ns / 1ps

module segment_intersection_core #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [sic_pkg::TOL_WIDTH-1:0]              csr_data,      // side_tolerance
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // first_start_x, first_start_y, first_end_x, first_end_y,
   // second_start_x, second_start_y, second_end_x, second_end_y
   input  logic [8*COORD_WIDTH-1:0]                   req_tdata,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // status, cross_x, cross_y, zero pad
   output logic [((2*COORD_WIDTH+2+7)/8)*8-1:0]       rsp_tdata
);

   localparam int W   = COORD_WIDTH;
   localparam int DMW = 2 * W + 2;
   localparam int Q   = W;
   localparam int AW  = DMW + Q;
   localparam int RSPW = ((2 * W + 2 + 7) / 8) * 8;

   logic [sic_pkg::TOL_WIDTH-1:0] tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   logic             cv   [Q+1];
   logic             cr   [Q+1];
   sic_pkg::ctl_type cctl [Q+1];
   logic [DMW-1:0]   cdm  [Q+1];
   logic [AW-1:0]    cax  [Q+1];
   logic [AW-1:0]    cay  [Q+1];

   sic_front #(.W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .tol       (tol_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (cv[0]),
      .out_ready (cr[0]),
      .out_ctl   (cctl[0]),
      .out_dm    (cdm[0]),
      .out_ax    (cax[0]),
      .out_ay    (cay[0])
   );

   for (genvar i = 0; i < Q; i++) begin : g_cell
      sic_div_cell #(.DMW(DMW), .Q(Q)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[i]),
         .in_ready  (cr[i]),
         .in_ctl    (cctl[i]),
         .in_dm     (cdm[i]),
         .in_ax     (cax[i]),
         .in_ay     (cay[i]),
         .out_valid (cv[i+1]),
         .out_ready (cr[i+1]),
         .out_ctl   (cctl[i+1]),
         .out_dm    (cdm[i+1]),
         .out_ax    (cax[i+1]),
         .out_ay    (cay[i+1])
      );
   end

   // saturation, sign and status masking
   function automatic logic [W-1:0] finish(logic [Q-1:0] q, logic neg, logic ovf);
      logic [W-1:0] half_rng;
      logic [W-1:0] lim;
      logic [W-1:0] qm;
      half_rng = {1'b1, {(W-1){1'b0}}};
      lim      = half_rng - {{(W-1){1'b0}}, ~neg};
      qm       = (ovf || q > lim) ? lim : q;
      return neg ? W'(-qm) : qm;
   endfunction

   logic                 out_valid_ff;
   logic [RSPW-1:0]      out_data_ff, out_data_in;
   logic [W-1:0]         fx, fy;
   sic_pkg::ctl_type     lc;

   always_comb begin
      lc = cctl[Q];
      fx = finish(cax[Q][Q-1:0], lc.neg_x, lc.ovf_x);
      fy = finish(cay[Q][Q-1:0], lc.neg_y, lc.ovf_y);
      if (lc.status != sic_pkg::ST_CROSS) begin
         fx = '0;
         fy = '0;
      end
      out_data_in = RSPW'({fy, fx, lc.status});
   end

   assign cr[Q] = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cr[Q]) begin
         out_valid_ff <= cv[Q];
      end
   end

   always_ff @(posedge clock) begin
      if (cr[Q]) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
